### rtl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int unsigned NUM_TASKS_DEF   = 8;
  localparam int unsigned STACK_BYTES_DEF = 1024;
  localparam int unsigned FRAME_BYTES     = 64;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned TID_W    = 3;
  localparam int unsigned SP_W     = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 3;

  localparam logic [SP_W-1:0] STACK_BASE_RESET = 32'h2000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_SWITCH  = 3'd1,
    OP_PAUSE   = 3'd2,
    OP_RESUME  = 3'd3,
    OP_DESTROY = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 2'd0,
    STS_NO_FREE    = 2'd1,
    STS_NO_RUN     = 2'd2,
    STS_NOT_IN_USE = 2'd3
  } status_e;

  typedef enum logic {
    SCAN_FREE,
    SCAN_RUNNABLE
  } scan_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_READ,
    S_FINISH
  } state_e;

endpackage

### rtl/rrts_stack_mem.sv
`timescale 1ns / 1ps

module rrts_stack_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rrts_slot_scan.sv
`timescale 1ns / 1ps

module rrts_slot_scan #(
  parameter int unsigned NUM_TASKS = 8,
  parameter int unsigned IW        = 3
) (
  input  rrts_pkg::scan_mode_e  mode_i,
  input  logic [IW-1:0]         cand_i,
  input  logic [NUM_TASKS-1:0]  in_use_i,
  input  logic [NUM_TASKS-1:0]  paused_i,
  output logic                  hit_o,
  output logic [IW-1:0]         cand_next_o
);

  import rrts_pkg::*;

  logic used;
  logic held;

  assign used = in_use_i[cand_i];
  assign held = paused_i[cand_i];

  always_comb begin
    case (mode_i)
      SCAN_FREE:     hit_o = !used;
      SCAN_RUNNABLE: hit_o = used && !held;
      default:       hit_o = 1'b0;
    endcase
  end

  // wrap to slot zero after the last slot
  assign cand_next_o = (cand_i == IW'(NUM_TASKS - 1)) ? '0 : cand_i + IW'(1);

endmodule

### rtl/round_robin_task_slot_scheduler.sv
`timescale 1ns / 1ps

// Round-robin task slot scheduler. Each request arrives as one transfer on the
// s_axis side (tuser carries the operation) and gives exactly one transfer on
// the m_axis side (tuser carries the status). Create claims the lowest free
// slot and returns stack_base + (slot+1)*STACK_BYTES - 64; switch, pause and
// destroy save the incoming stack pointer for the current task and pick the
// next runnable slot after it, returning the pointer saved for that slot;
// resume clears a slot's pause mark. A single slot test unit examines one slot
// per cycle. Create runs start, slot scan and finish (output register load);
// switch, pause and destroy add a stack pointer memory read before finish;
// resume and unused codes skip the scan. s_axis_tready is high only while no
// request is being worked on; a result may wait in the output register while
// the next request is accepted. stack_base is written through cfg_we_i /
// cfg_wdata_i; the user must do so only while the block idles (not enforced).
module round_robin_task_slot_scheduler #(
  parameter int unsigned NUM_TASKS   = rrts_pkg::NUM_TASKS_DEF,
  parameter int unsigned STACK_BYTES = rrts_pkg::STACK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // task_id [2:0], saved_sp [34:3], zero [39:35]
  input  logic [39:0] s_axis_tdata,
  // op [2:0]
  input  logic [2:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // task_index [2:0], stack_ptr [34:3], running_valid [35], zero [39:36]
  output logic [39:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]  m_axis_tuser
);

  import rrts_pkg::*;

  localparam int unsigned IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  state_e state_q, state_d;

  logic [SP_W-1:0]      stack_base_q;
  logic [NUM_TASKS-1:0] in_use_q, in_use_d;
  logic [NUM_TASKS-1:0] paused_q, paused_d;
  logic [IW-1:0]        cur_q, cur_d;
  logic                 cur_valid_q, cur_valid_d;

  op_e              op_q, op_d;
  logic [TID_W-1:0] tid_q, tid_d;
  logic [SP_W-1:0]  sp_q, sp_d;
  logic [IW-1:0]    cand_q, cand_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  scan_mode_e       mode_q, mode_d;

  status_e          res_status_q, res_status_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic [SP_W-1:0]  res_sp_q, res_sp_d;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [SP_W-1:0]  out_sp_q;
  logic             out_rv_q;
  logic             out_load;

  logic          scan_hit;
  logic [IW-1:0] scan_cand;
  logic [IW-1:0] scan_next;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [SP_W-1:0] mem_wdata;
  logic            mem_re;
  logic [SP_W-1:0] mem_rdata;

  logic [SP_W-1:0] create_sp;
  logic            tid_in_range;
  logic            scan_last;
  logic            in_accept;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  assign create_sp = stack_base_q
                   + ((SP_W'(cand_q) + SP_W'(1)) * SP_W'(STACK_BYTES))
                   - SP_W'(FRAME_BYTES);
  assign tid_in_range = (32'(tid_q) < 32'(NUM_TASKS));
  assign scan_last    = (cnt_q == IW'(NUM_TASKS - 1));

  // in the start cycle the unit gives the slot after the current one
  assign scan_cand = (state_q == S_START) ? cur_q : cand_q;

  rrts_slot_scan #(
    .NUM_TASKS (NUM_TASKS),
    .IW        (IW)
  ) u_scan (
    .mode_i      (mode_q),
    .cand_i      (scan_cand),
    .in_use_i    (in_use_q),
    .paused_i    (paused_q),
    .hit_o       (scan_hit),
    .cand_next_o (scan_next)
  );

  rrts_stack_mem #(
    .DEPTH (NUM_TASKS),
    .AW    (IW),
    .DW    (SP_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cand_q),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_base_q <= STACK_BASE_RESET;
    end else if (cfg_we_i) begin
      stack_base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_use_q    <= '0;
      paused_q    <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      op_q        <= OP_CREATE;
      tid_q       <= '0;
      sp_q        <= '0;
      cand_q      <= '0;
      cnt_q       <= '0;
      mode_q      <= SCAN_FREE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      paused_q    <= paused_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      op_q        <= op_d;
      tid_q       <= tid_d;
      sp_q        <= sp_d;
      cand_q      <= cand_d;
      cnt_q       <= cnt_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_sp_q     <= res_sp_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_sp_q     <= res_sp_q;
      out_rv_q     <= cur_valid_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_use_d     = in_use_q;
    paused_d     = paused_q;
    cur_d        = cur_q;
    cur_valid_d  = cur_valid_q;
    op_d         = op_q;
    tid_d        = tid_q;
    sp_d         = sp_q;
    cand_d       = cand_q;
    cnt_d        = cnt_q;
    mode_d       = mode_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_sp_d     = res_sp_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_q;
    mem_wdata    = sp_q;
    mem_re       = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d    = op_e'(s_axis_tuser);
          tid_d   = s_axis_tdata[2:0];
          sp_d    = s_axis_tdata[34:3];
          mode_d  = (op_e'(s_axis_tuser) == OP_CREATE) ? SCAN_FREE : SCAN_RUNNABLE;
          state_d = S_START;
        end
      end

      S_START: begin
        cnt_d = '0;
        case (op_q)
          OP_CREATE: begin
            cand_d  = '0;
            state_d = S_SCAN;
          end
          OP_SWITCH, OP_PAUSE, OP_DESTROY: begin
            if (cur_valid_q) begin
              mem_we = 1'b1;
              if (op_q == OP_PAUSE) begin
                paused_d[cur_q] = 1'b1;
              end
              if (op_q == OP_DESTROY) begin
                in_use_d[cur_q] = 1'b0;
                paused_d[cur_q] = 1'b0;
              end
              cand_d = scan_next;
            end else begin
              cand_d = '0;
            end
            state_d = S_SCAN;
          end
          OP_RESUME: begin
            res_idx_d = tid_q;
            res_sp_d  = '0;
            if (tid_in_range) begin
              paused_d[IW'(tid_q)] = 1'b0;
              res_status_d = in_use_q[IW'(tid_q)] ? STS_OK : STS_NOT_IN_USE;
            end else begin
              res_status_d = STS_NOT_IN_USE;
            end
            state_d = S_FINISH;
          end
          default: begin
            res_status_d = STS_OK;
            res_idx_d    = IDX_W'(cur_q);
            res_sp_d     = '0;
            state_d      = S_FINISH;
          end
        endcase
      end

      S_SCAN: begin
        if (scan_hit) begin
          res_status_d = STS_OK;
          res_idx_d    = IDX_W'(cand_q);
          if (mode_q == SCAN_FREE) begin
            mem_we           = 1'b1;
            mem_waddr        = cand_q;
            mem_wdata        = create_sp;
            in_use_d[cand_q] = 1'b1;
            paused_d[cand_q] = 1'b0;
            res_sp_d         = create_sp;
            state_d          = S_FINISH;
          end else begin
            mem_re      = 1'b1;
            cur_d       = cand_q;
            cur_valid_d = 1'b1;
            state_d     = S_READ;
          end
        end else if (scan_last) begin
          res_sp_d = '0;
          if (mode_q == SCAN_FREE) begin
            res_status_d = STS_NO_FREE;
            res_idx_d    = '0;
          end else begin
            res_status_d = STS_NO_RUN;
            res_idx_d    = IDX_W'(cur_q);
            cur_valid_d  = 1'b0;
          end
          state_d = S_FINISH;
        end else begin
          cand_d = scan_next;
          cnt_d  = cnt_q + IW'(1);
        end
      end

      S_READ: begin
        res_sp_d = mem_rdata;
        state_d  = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {4'd0, out_rv_q, out_sp_q, out_idx_q};

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_START))
    else $error("accepted transfer did not start work");

  a_read_runnable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (in_use_q[cand_q] && !paused_q[cand_q]))
    else $error("stack pointer read for a slot that is not runnable");

  a_current_runnable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && cur_valid_q) |-> (in_use_q[cur_q] && !paused_q[cur_q]))
    else $error("current task is free or paused while idle");

  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_FINISH))
    else $error("result shown without a finished request");

endmodule
